>>> hdl/quaternion_to_rotation_matrix_core_assert.svh
// assertion macros for the quaternion to rotation matrix core
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_ASSERT_SVH

// same-cycle implication, ignored during reset
`define Q2R_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("q2r assertion failed");

// next-cycle implication, ignored during reset
`define Q2R_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("q2r assertion failed");

// next-cycle implication that also holds across reset
`define Q2R_ASSERT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("q2r assertion failed");

`endif

>>> hdl/q2r_pkg.sv
// shared widths, types and helpers of the quaternion to rotation matrix core
`timescale 1ns / 1ps

package q2r_pkg;

  localparam int CW = 16;
  localparam int EW = 16;
  localparam int LANES = 9;
  localparam int PW = 2 * CW - 1;
  localparam int SW = 2 * CW;
  localparam int NW = 2 * CW + 1;
  localparam int QW = EW;
  localparam int DSH_W = NW + QW;
  localparam int RW = DSH_W + 1;
  localparam int DIV_STEPS = QW;

  localparam int C_X = 0;
  localparam int C_Y = 1;
  localparam int C_Z = 2;
  localparam int C_W = 3;

  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_WW = 3;
  localparam int P_XY = 4;
  localparam int P_XZ = 5;
  localparam int P_YZ = 6;
  localparam int P_WX = 7;
  localparam int P_WY = 8;
  localparam int P_WZ = 9;
  localparam int NPROD = 10;

  localparam logic [LANES-1:0] DIAG_LANES = 9'b100010001;

  localparam logic [EW-1:0] ENTRY_ONE = {2'b01, {(EW - 2){1'b0}}};
  localparam logic signed [EW:0] ENTRY_MAX = {2'b00, {(EW - 1){1'b1}}};
  localparam logic signed [EW:0] ENTRY_MIN = {2'b11, {(EW - 1){1'b0}}};

  typedef struct packed {
    logic          neg;
    logic [SW-1:0] mag;
  } q2r_sm_t;

  typedef struct packed {
    logic                      zero;
    logic [LANES-1:0]          neg;
    logic [LANES-1:0][RW-1:0]  rem;
    logic [LANES-1:0][QW-1:0]  quo;
    logic [DSH_W-1:0]          dsh;
  } q2r_div_t;

  function automatic q2r_sm_t sm_add(input logic n1, input logic [SW-1:0] m1,
                                     input logic n2, input logic [SW-1:0] m2);
    q2r_sm_t r;
    if (n1 == n2) begin
      r.neg = n1;
      r.mag = m1 + m2;
    end else if (m1 >= m2) begin
      r.neg = n1;
      r.mag = m1 - m2;
    end else begin
      r.neg = n2;
      r.mag = m2 - m1;
    end
    return r;
  endfunction

endpackage

>>> hdl/q2r_if.sv
// channel interfaces: quaternion in, matrix out
`timescale 1ns / 1ps

interface q2r_quat_if;
  logic                           valid;
  logic                           ready;
  logic signed [q2r_pkg::CW-1:0]  quat_x;
  logic signed [q2r_pkg::CW-1:0]  quat_y;
  logic signed [q2r_pkg::CW-1:0]  quat_z;
  logic signed [q2r_pkg::CW-1:0]  quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2r_mat_if;
  logic                           valid;
  logic                           ready;
  logic signed [q2r_pkg::EW-1:0]  m00;
  logic signed [q2r_pkg::EW-1:0]  m01;
  logic signed [q2r_pkg::EW-1:0]  m02;
  logic signed [q2r_pkg::EW-1:0]  m10;
  logic signed [q2r_pkg::EW-1:0]  m11;
  logic signed [q2r_pkg::EW-1:0]  m12;
  logic signed [q2r_pkg::EW-1:0]  m20;
  logic signed [q2r_pkg::EW-1:0]  m21;
  logic signed [q2r_pkg::EW-1:0]  m22;
  logic                           clipped;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, clipped,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, clipped,
                output ready);
endinterface

>>> hdl/q2r_front.sv
// front stages: magnitudes, products, signed sums, dividends
`timescale 1ns / 1ps

module q2r_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [q2r_pkg::CW-1:0]  x,
  input  logic signed [q2r_pkg::CW-1:0]  y,
  input  logic signed [q2r_pkg::CW-1:0]  z,
  input  logic signed [q2r_pkg::CW-1:0]  w,
  output logic                           out_valid,
  output q2r_pkg::q2r_div_t              out_data
);

  logic [2:0]                          v;
  logic [3:0][q2r_pkg::CW-1:0]         mg;
  logic [3:0]                          sg;
  logic [3:0][q2r_pkg::CW-1:0]         mg_next;
  logic [q2r_pkg::NPROD-1:0][q2r_pkg::PW-1:0] prod;
  logic [q2r_pkg::NPROD-1:0][q2r_pkg::PW-1:0] prod_next;
  logic [3:0]                          sg2;
  q2r_pkg::q2r_sm_t [q2r_pkg::LANES-1:0] sm;
  q2r_pkg::q2r_sm_t [q2r_pkg::LANES-1:0] sm_next;
  logic [q2r_pkg::NW-1:0]              norm;
  logic [q2r_pkg::NW-1:0]              norm_next;
  q2r_pkg::q2r_div_t                   div_next;

  logic [3:0][q2r_pkg::CW-1:0] comp;
  assign comp = {w, z, y, x};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mg_next[i] = comp[i][q2r_pkg::CW-1] ? (~comp[i] + 1'b1) : comp[i];
    end
  end

  function automatic logic [q2r_pkg::PW-1:0] mul(input logic [q2r_pkg::CW-1:0] a,
                                                 input logic [q2r_pkg::CW-1:0] b);
    logic [2*q2r_pkg::CW-1:0] full;
    full = a * b;
    return full[q2r_pkg::PW-1:0];
  endfunction

  always_comb begin
    prod_next[q2r_pkg::P_XX] = mul(mg[q2r_pkg::C_X], mg[q2r_pkg::C_X]);
    prod_next[q2r_pkg::P_YY] = mul(mg[q2r_pkg::C_Y], mg[q2r_pkg::C_Y]);
    prod_next[q2r_pkg::P_ZZ] = mul(mg[q2r_pkg::C_Z], mg[q2r_pkg::C_Z]);
    prod_next[q2r_pkg::P_WW] = mul(mg[q2r_pkg::C_W], mg[q2r_pkg::C_W]);
    prod_next[q2r_pkg::P_XY] = mul(mg[q2r_pkg::C_X], mg[q2r_pkg::C_Y]);
    prod_next[q2r_pkg::P_XZ] = mul(mg[q2r_pkg::C_X], mg[q2r_pkg::C_Z]);
    prod_next[q2r_pkg::P_YZ] = mul(mg[q2r_pkg::C_Y], mg[q2r_pkg::C_Z]);
    prod_next[q2r_pkg::P_WX] = mul(mg[q2r_pkg::C_W], mg[q2r_pkg::C_X]);
    prod_next[q2r_pkg::P_WY] = mul(mg[q2r_pkg::C_W], mg[q2r_pkg::C_Y]);
    prod_next[q2r_pkg::P_WZ] = mul(mg[q2r_pkg::C_W], mg[q2r_pkg::C_Z]);
  end

  function automatic logic [q2r_pkg::SW-1:0] ext(input logic [q2r_pkg::PW-1:0] p);
    return {{(q2r_pkg::SW - q2r_pkg::PW){1'b0}}, p};
  endfunction

  logic sxy, sxz, syz, swx, swy, swz;
  logic [q2r_pkg::SW-1:0] s_xw, s_yw, s_zw, s_yz, s_xz, s_xy;

  always_comb begin
    sxy = sg2[q2r_pkg::C_X] ^ sg2[q2r_pkg::C_Y];
    sxz = sg2[q2r_pkg::C_X] ^ sg2[q2r_pkg::C_Z];
    syz = sg2[q2r_pkg::C_Y] ^ sg2[q2r_pkg::C_Z];
    swx = sg2[q2r_pkg::C_W] ^ sg2[q2r_pkg::C_X];
    swy = sg2[q2r_pkg::C_W] ^ sg2[q2r_pkg::C_Y];
    swz = sg2[q2r_pkg::C_W] ^ sg2[q2r_pkg::C_Z];
    s_xw = ext(prod[q2r_pkg::P_XX]) + ext(prod[q2r_pkg::P_WW]);
    s_yw = ext(prod[q2r_pkg::P_YY]) + ext(prod[q2r_pkg::P_WW]);
    s_zw = ext(prod[q2r_pkg::P_ZZ]) + ext(prod[q2r_pkg::P_WW]);
    s_yz = ext(prod[q2r_pkg::P_YY]) + ext(prod[q2r_pkg::P_ZZ]);
    s_xz = ext(prod[q2r_pkg::P_XX]) + ext(prod[q2r_pkg::P_ZZ]);
    s_xy = ext(prod[q2r_pkg::P_XX]) + ext(prod[q2r_pkg::P_YY]);
    norm_next = {1'b0, s_xy} + {1'b0, s_zw};
    sm_next[0] = q2r_pkg::sm_add(1'b0, s_xw, 1'b1, s_yz);
    sm_next[1] = q2r_pkg::sm_add(sxy, ext(prod[q2r_pkg::P_XY]), !swz, ext(prod[q2r_pkg::P_WZ]));
    sm_next[2] = q2r_pkg::sm_add(sxz, ext(prod[q2r_pkg::P_XZ]), swy, ext(prod[q2r_pkg::P_WY]));
    sm_next[3] = q2r_pkg::sm_add(sxy, ext(prod[q2r_pkg::P_XY]), swz, ext(prod[q2r_pkg::P_WZ]));
    sm_next[4] = q2r_pkg::sm_add(1'b0, s_yw, 1'b1, s_xz);
    sm_next[5] = q2r_pkg::sm_add(syz, ext(prod[q2r_pkg::P_YZ]), !swx, ext(prod[q2r_pkg::P_WX]));
    sm_next[6] = q2r_pkg::sm_add(sxz, ext(prod[q2r_pkg::P_XZ]), !swy, ext(prod[q2r_pkg::P_WY]));
    sm_next[7] = q2r_pkg::sm_add(syz, ext(prod[q2r_pkg::P_YZ]), swx, ext(prod[q2r_pkg::P_WX]));
    sm_next[8] = q2r_pkg::sm_add(1'b0, s_zw, 1'b1, s_xy);
  end

  // dividend is m * 2^shift + n, divisor 2n aligned to the top quotient bit
  always_comb begin
    div_next.zero = (norm == '0);
    div_next.dsh = {norm, {q2r_pkg::QW{1'b0}}};
    for (int i = 0; i < q2r_pkg::LANES; i++) begin
      div_next.neg[i] = sm[i].neg;
      div_next.quo[i] = '0;
      if (q2r_pkg::DIAG_LANES[i]) begin
        div_next.rem[i] = {3'b000, sm[i].mag, {(q2r_pkg::EW - 1){1'b0}}}
                          + {{(q2r_pkg::RW - q2r_pkg::NW){1'b0}}, norm};
      end else begin
        div_next.rem[i] = {2'b00, sm[i].mag, {q2r_pkg::EW{1'b0}}}
                          + {{(q2r_pkg::RW - q2r_pkg::NW){1'b0}}, norm};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      v[1] <= v[0];
      v[2] <= v[1];
      out_valid <= v[2];
    end
    if (en) begin
      mg <= mg_next;
      sg <= {w[q2r_pkg::CW-1], z[q2r_pkg::CW-1], y[q2r_pkg::CW-1], x[q2r_pkg::CW-1]};
      prod <= prod_next;
      sg2 <= sg;
      sm <= sm_next;
      norm <= norm_next;
      out_data <= div_next;
    end
  end

endmodule

>>> hdl/q2r_div_step.sv
// one restoring division step for all nine lanes
`timescale 1ns / 1ps

module q2r_div_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  q2r_pkg::q2r_div_t  in_data,
  output logic               out_valid,
  output q2r_pkg::q2r_div_t  out_data
);

  q2r_pkg::q2r_div_t       data_next;
  logic [q2r_pkg::RW-1:0]  dsh_ext;
  logic [q2r_pkg::RW-1:0]  diff;
  logic                    ge;

  always_comb begin
    data_next = in_data;
    dsh_ext = {1'b0, in_data.dsh};
    diff = '0;
    ge = 1'b0;
    for (int i = 0; i < q2r_pkg::LANES; i++) begin
      ge = in_data.rem[i] >= dsh_ext;
      diff = ge ? (in_data.rem[i] - dsh_ext) : in_data.rem[i];
      data_next.rem[i] = {diff[q2r_pkg::RW-2:0], 1'b0};
      data_next.quo[i] = {in_data.quo[i][q2r_pkg::QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

>>> hdl/q2r_back.sv
// output stage: sign, saturation, identity for a zero quaternion
`timescale 1ns / 1ps

module q2r_back (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  q2r_pkg::q2r_div_t                          in_data,
  output logic                                       out_valid,
  output logic [q2r_pkg::LANES-1:0][q2r_pkg::EW-1:0] out_entries,
  output logic                                       out_clipped
);

  logic [q2r_pkg::LANES-1:0][q2r_pkg::EW-1:0] entries_next;
  logic                                       clipped_next;
  logic signed [q2r_pkg::EW:0]                qe;
  logic signed [q2r_pkg::EW:0]                r;

  always_comb begin
    clipped_next = 1'b0;
    qe = '0;
    r = '0;
    for (int i = 0; i < q2r_pkg::LANES; i++) begin
      qe = {1'b0, in_data.quo[i]};
      r = in_data.neg[i] ? -qe : qe;
      if (r > q2r_pkg::ENTRY_MAX) begin
        entries_next[i] = q2r_pkg::ENTRY_MAX[q2r_pkg::EW-1:0];
        clipped_next = 1'b1;
      end else if (r < q2r_pkg::ENTRY_MIN) begin
        entries_next[i] = q2r_pkg::ENTRY_MIN[q2r_pkg::EW-1:0];
        clipped_next = 1'b1;
      end else begin
        entries_next[i] = r[q2r_pkg::EW-1:0];
      end
    end
    if (in_data.zero) begin
      clipped_next = 1'b0;
      for (int i = 0; i < q2r_pkg::LANES; i++) begin
        entries_next[i] = q2r_pkg::DIAG_LANES[i] ? q2r_pkg::ENTRY_ONE : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_entries <= entries_next;
      out_clipped <= clipped_next;
    end
  end

endmodule

>>> hdl/quaternion_to_rotation_matrix_core.sv
// top level of the quaternion to rotation matrix core
//
// quat is a valid/ready sink carrying one quaternion (x, y, z, w) in signed
// Q3.12 per transfer; matrix is a valid/ready source carrying the nine
// signed Q2.14 entries and the clipped flag per transfer.
// the pipeline is 21 register stages deep: four front stages (magnitudes,
// 16x16 products, signed sums, dividends), sixteen division stages that each
// retire one quotient bit of all nine entries, and one output register.
// one item is taken every cycle unless matrix is stalled with a valid result,
// the divider being pipelined at one quotient bit per stage.
// the whole pipeline advances together: when matrix is stalled with a valid
// result, every stage holds and quat.ready drops; nothing is lost or repeated.
// synchronous reset clears all valid bits, so matrix.valid is low after reset
// and quat.ready is high.
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_core (
  input  logic       clk,
  input  logic       rst,
  q2r_quat_if.sink   quat,
  q2r_mat_if.source  matrix
);

  logic                                       en;
  logic                                       front_valid;
  q2r_pkg::q2r_div_t                          front_data;
  logic [q2r_pkg::DIV_STEPS:0]                step_valid;
  q2r_pkg::q2r_div_t [q2r_pkg::DIV_STEPS:0]   step_data;
  logic [q2r_pkg::LANES-1:0][q2r_pkg::EW-1:0] entries;

  assign en = !matrix.valid || matrix.ready;
  assign quat.ready = en;

  q2r_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quat.valid),
    .x         (quat.quat_x),
    .y         (quat.quat_y),
    .z         (quat.quat_z),
    .w         (quat.quat_w),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  assign step_valid[0] = front_valid;
  assign step_data[0] = front_data;

  for (genvar g = 0; g < q2r_pkg::DIV_STEPS; g++) begin : g_div
    q2r_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (step_valid[g]),
      .in_data   (step_data[g]),
      .out_valid (step_valid[g+1]),
      .out_data  (step_data[g+1])
    );
  end

  q2r_back u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (step_valid[q2r_pkg::DIV_STEPS]),
    .in_data     (step_data[q2r_pkg::DIV_STEPS]),
    .out_valid   (matrix.valid),
    .out_entries (entries),
    .out_clipped (matrix.clipped)
  );

  assign matrix.m00 = entries[0];
  assign matrix.m01 = entries[1];
  assign matrix.m02 = entries[2];
  assign matrix.m10 = entries[3];
  assign matrix.m11 = entries[4];
  assign matrix.m12 = entries[5];
  assign matrix.m20 = entries[6];
  assign matrix.m21 = entries[7];
  assign matrix.m22 = entries[8];

endmodule

>>> hdl/q2r_checker.sv
// port-level checks of the quaternion to rotation matrix core
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_core_assert.svh"

module q2r_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [q2r_pkg::EW-1:0] m00,
  input logic signed [q2r_pkg::EW-1:0] m01,
  input logic signed [q2r_pkg::EW-1:0] m02,
  input logic signed [q2r_pkg::EW-1:0] m10,
  input logic signed [q2r_pkg::EW-1:0] m11,
  input logic signed [q2r_pkg::EW-1:0] m12,
  input logic signed [q2r_pkg::EW-1:0] m20,
  input logic signed [q2r_pkg::EW-1:0] m21,
  input logic signed [q2r_pkg::EW-1:0] m22,
  input logic                          clipped
);

  logic [q2r_pkg::LANES*q2r_pkg::EW:0] out_word;
  assign out_word = {m00, m01, m02, m10, m11, m12, m20, m21, m22, clipped};

  `Q2R_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `Q2R_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))
  `Q2R_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid)
  `Q2R_ASSERT_NOW(a_ready_when_free, !out_valid || out_ready, in_ready)

endmodule

bind quaternion_to_rotation_matrix_core q2r_checker u_q2r_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (quat.ready),
  .out_valid (matrix.valid),
  .out_ready (matrix.ready),
  .m00       (matrix.m00),
  .m01       (matrix.m01),
  .m02       (matrix.m02),
  .m10       (matrix.m10),
  .m11       (matrix.m11),
  .m12       (matrix.m12),
  .m20       (matrix.m20),
  .m21       (matrix.m21),
  .m22       (matrix.m22),
  .clipped   (matrix.clipped)
);
